[rtl/itf_pkg.sv]
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants of the integer text formatter
// Format codes, ASCII constants, the digit generator control bundle and
// the digit-to-character mapping.
// ----------------------------------------------------------------------------
package itf_pkg;

  // Conversion selected by the format code. Unused codes act as unsigned decimal.
  typedef enum logic [2:0] {
    FMT_OCT  = 3'd0,
    FMT_SDEC = 3'd1,
    FMT_UDEC = 3'd2,
    FMT_LHEX = 3'd3,
    FMT_UHEX = 3'd4
  } fmt_code_t;

  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_MINUS   = 7'h2d;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_LOWER_A = 7'h61;

  // Control from the sequencer to the digit generator.
  typedef struct packed {
    logic start;    // load a new magnitude
    logic octal;    // digits are three bits wide
    logic decimal;  // convert to BCD before the digits are read
    logic take;     // the top digit has been used; move to the next one
  } dig_ctrl_t;

  // One digit value (0 to 15) as an ASCII character.
  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic caps);
    logic [6:0] base;
    base = caps ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {3'b000, d};
    end else begin
      digit_char = base + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

[rtl/itf_in_if.sv]
// ----------------------------------------------------------------------------
// itf_in_if: input channel of the integer text formatter
// One beat carries an integer and its format settings.
// ----------------------------------------------------------------------------
interface itf_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [2:0]         format_code;
  logic               pad_left;
  logic               zero_fill;
  logic [6:0]         field_width;
  logic [5:0]         digit_precision;

  modport source (
    output valid, value, format_code, pad_left, zero_fill, field_width, digit_precision,
    input  ready
  );
  modport sink (
    input  valid, value, format_code, pad_left, zero_fill, field_width, digit_precision,
    output ready
  );
endinterface

[rtl/itf_out_if.sv]
// ----------------------------------------------------------------------------
// itf_out_if: output channel of the integer text formatter
// One beat carries one ASCII character and an end-of-text mark.
// ----------------------------------------------------------------------------
interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

[rtl/itf_digit_gen.sv]
// ----------------------------------------------------------------------------
// itf_digit_gen: digit generator
// Turns a magnitude into octal, decimal or hex digits. Decimal goes through
// a bit-serial double dabble; leading zero digits are then shifted out one
// per cycle, which leaves the digit count and the leading digit at the top.
// ----------------------------------------------------------------------------
module itf_digit_gen #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  itf_pkg::dig_ctrl_t    ctrl,
  input  logic [VALUE_BITS-1:0] mag,
  output logic                  done,
  output logic [$clog2((VALUE_BITS+2)/3+1)-1:0] count,
  output logic [3:0]            top_digit
);

  localparam int SLOTS = (VALUE_BITS + 2) / 3;
  localparam int DW    = 4 * SLOTS;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int BW    = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    G_IDLE  = 4'b0001,
    G_CONV  = 4'b0010,
    G_NORM  = 4'b0100,
    G_READY = 4'b1000
  } gen_state_t;

  gen_state_t            state;
  logic [DW-1:0]         dreg;
  logic [VALUE_BITS-1:0] sh;
  logic [BW-1:0]         bits_left;
  logic [CW-1:0]         cnt;
  logic                  oct;

  logic [DW-1:0] corrected;
  logic [DW-1:0] shifted;

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      corrected[4*i +: 4] = (dreg[4*i +: 4] >= 4'd5) ? dreg[4*i +: 4] + 4'd3
                                                      : dreg[4*i +: 4];
    end
  end

  assign top_digit = oct ? {1'b0, dreg[3*SLOTS-1 -: 3]} : dreg[DW-1 -: 4];
  assign shifted   = oct ? (dreg << 3) : (dreg << 4);
  assign done      = (state == G_READY);
  assign count     = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
    end else if (ctrl.start) begin
      oct <= ctrl.octal;
      cnt <= CW'(SLOTS);
      if (ctrl.decimal) begin
        dreg      <= '0;
        sh        <= mag;
        bits_left <= BW'(VALUE_BITS);
        state     <= G_CONV;
      end else begin
        dreg  <= {{(DW-VALUE_BITS){1'b0}}, mag};
        state <= G_NORM;
      end
    end else begin
      unique case (state)
        G_IDLE: begin
        end
        G_CONV: begin
          dreg      <= {corrected[DW-2:0], sh[VALUE_BITS-1]};
          sh        <= sh << 1;
          bits_left <= bits_left - BW'(1);
          if (bits_left == BW'(1)) begin
            state <= G_NORM;
          end
        end
        G_NORM: begin
          if (cnt != CW'(1) && top_digit == 4'd0) begin
            dreg <= shifted;
            cnt  <= cnt - CW'(1);
          end else begin
            state <= G_READY;
          end
        end
        G_READY: begin
          if (ctrl.take) begin
            dreg <= shifted;
            cnt  <= cnt - CW'(1);
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

endmodule

[rtl/integer_text_formatter_unit.sv]
// ----------------------------------------------------------------------------
// integer_text_formatter_unit: printf-style text for one integer
// Steps: after the accepting edge come the BCD conversion (decimal only),
//   the drop of leading zero digits, setup and the load of the first character.
// Throughput: one item at a time; the next beat is taken once the last
//   character has been placed in the output register, one character per cycle while the output is not stalled.
// Reset: synchronous, active high; clears the sequencer and the output valid.
//
// The integer is reduced to a magnitude and a minus flag when it is taken.
// The digit generator produces the digits most significant first and
// reports their count; the setup cycle works out the zero fill, the space
// padding and the total length, and the emitter walks through the parts of
// the text in order: leading spaces, sign, zeros, digits, trailing spaces.
// ----------------------------------------------------------------------------
module integer_text_formatter_unit #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_FIELD  = 64
) (
  input  logic     clk,
  input  logic     rst,
  itf_in_if.sink   item,
  itf_out_if.source text
);

  localparam int SLOTS = (VALUE_BITS + 2) / 3;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int FW    = $clog2(MAX_FIELD + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WORK  = 4'b0010,
    S_SETUP = 4'b0100,
    S_EMIT  = 4'b1000
  } seq_state_t;

  seq_state_t state;

  // Settings of the item in flight.
  logic       pad;
  logic       zfill;
  logic       caps;
  logic       neg;
  logic [6:0] wid;
  logic [5:0] prec;

  // Part counters used while the text goes out.
  logic [FW-1:0] spaces;
  logic [FW-1:0] zeros;
  logic [FW-1:0] rem;

  // Output register.
  logic       ovalid;
  logic [6:0] ochar;
  logic       olast;

  itf_pkg::dig_ctrl_t dig_ctrl;
  logic               dig_done;
  logic [CW-1:0]      dig_count;
  logic [3:0]         dig_top;

  logic                  accept;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_bits;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  in_octal;
  logic                  in_hex;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  // Magnitude of the value: two's complement negation only for a negative
  // number in signed decimal mode, so the most negative value wraps to its
  // correct unsigned magnitude.
  assign in_bits  = item.value[VALUE_BITS-1:0];
  assign in_neg   = (item.format_code == itf_pkg::FMT_SDEC) && in_bits[VALUE_BITS-1];
  assign in_mag   = in_neg ? ({VALUE_BITS{1'b0}} - in_bits) : in_bits;
  assign in_octal = (item.format_code == itf_pkg::FMT_OCT);
  assign in_hex   = (item.format_code == itf_pkg::FMT_LHEX) ||
                    (item.format_code == itf_pkg::FMT_UHEX);

  // Setup arithmetic, in nine signed bits so that every difference fits.
  logic signed [8:0] place9, wid9, prec9, sign9;
  logic signed [8:0] zero_raw, zero_cnt, space_raw, space_cnt, total;

  always_comb begin
    place9 = $signed(9'(dig_count));
    wid9   = $signed({2'b00, wid});
    prec9  = $signed({3'b000, prec});
    sign9  = neg ? 9'sd1 : 9'sd0;
    if (prec != 6'd0) begin
      zero_raw = prec9 - place9;
    end else if (zfill && pad) begin
      zero_raw = wid9 - place9 - sign9;
    end else begin
      zero_raw = 9'sd0;
    end
    zero_cnt  = (zero_raw < 9'sd0) ? 9'sd0 : zero_raw;
    space_raw = wid9 - place9 - zero_cnt - sign9;
    space_cnt = (space_raw < 9'sd0) ? 9'sd0 : space_raw;
    total     = space_cnt + zero_cnt + place9 + sign9;
  end

  // The output register may be refilled when it is empty or being drained.
  logic       fire;
  logic       use_digit;
  logic [6:0] pick_char;

  assign fire = (state == S_EMIT) && (!ovalid || text.ready);

  // Choose the next character. Leading spaces exist only with pad-left, so
  // the final arm can only be reached by trailing spaces.
  always_comb begin
    use_digit = 1'b0;
    if (pad && spaces != '0) begin
      pick_char = itf_pkg::CH_SPACE;
    end else if (neg) begin
      pick_char = itf_pkg::CH_MINUS;
    end else if (zeros != '0) begin
      pick_char = itf_pkg::CH_ZERO;
    end else if (dig_count != '0) begin
      pick_char = itf_pkg::digit_char(dig_top, caps);
      use_digit = 1'b1;
    end else begin
      pick_char = itf_pkg::CH_SPACE;
    end
  end

  assign dig_ctrl.start   = accept;
  assign dig_ctrl.octal   = in_octal;
  assign dig_ctrl.decimal = !in_octal && !in_hex;
  assign dig_ctrl.take    = fire && use_digit;

  itf_digit_gen #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit_gen (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (dig_ctrl),
    .mag       (in_mag),
    .done      (dig_done),
    .count     (dig_count),
    .top_digit (dig_top)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (dig_done) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (fire && rem == FW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item settings and part counters; width and precision saturate to the
  // field limits here.
  always_ff @(posedge clk) begin
    if (accept) begin
      pad   <= item.pad_left;
      zfill <= item.zero_fill;
      caps  <= (item.format_code == itf_pkg::FMT_UHEX);
      neg   <= in_neg;
      wid   <= (item.field_width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : item.field_width;
      prec  <= ({1'b0, item.digit_precision} > 7'(MAX_FIELD - 1)) ? 6'(MAX_FIELD - 1)
                                                                  : item.digit_precision;
    end else if (state == S_SETUP) begin
      zeros  <= zero_cnt[FW-1:0];
      spaces <= space_cnt[FW-1:0];
      rem    <= total[FW-1:0];
    end else if (fire) begin
      rem <= rem - FW'(1);
      if (pad && spaces != '0) begin
        spaces <= spaces - FW'(1);
      end else if (neg) begin
        neg <= 1'b0;
      end else if (zeros != '0) begin
        zeros <= zeros - FW'(1);
      end else if (!use_digit) begin
        spaces <= spaces - FW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (fire) begin
      ovalid <= 1'b1;
    end else if (text.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ochar <= pick_char;
      olast <= (rem == FW'(1));
    end
  end

  assign text.valid     = ovalid;
  assign text.char_code = ochar;
  assign text.last      = olast;

  // A taken beat always starts the digit generator's work.
  a_accept_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_WORK))
    else $error("accepted beat did not start conversion");

  // Setup reads the digit count only once the generator has finished.
  a_setup_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP) |-> dig_done)
    else $error("setup before digits were ready");

  // A digit is never taken beyond the count that the generator holds.
  a_digit_left: assert property (@(posedge clk) disable iff (rst)
    dig_ctrl.take |-> (dig_count != '0) && dig_done)
    else $error("digit taken with none left");

  // The final character of an item is marked and the sequencer goes idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && rem == FW'(1)) |=> (text.valid && text.last && state == S_IDLE))
    else $error("final character not marked");

  // No item's text is empty: the setup always sees at least one digit.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETUP) |-> (dig_count != '0))
    else $error("empty digit string");

endmodule
